[src/quaternion_slerp_core_assert.svh]
// Assertion macros for the quaternion slerp core.
`ifndef QUATERNION_SLERP_CORE_ASSERT_SVH
`define QUATERNION_SLERP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define QSL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("quaternion slerp core check failed");
`define QSL_ASSERT_ANY(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("quaternion slerp core reset check failed");
`else
`define QSL_ASSERT(lbl, prop)
`define QSL_ASSERT_ANY(lbl, prop)
`endif
`endif

[src/qsl_pkg.sv]
// Shared constants, cell data types and the CORDIC angle table.
package qsl_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQ_STEPS      = 32;
    localparam int DIV_STEPS     = 31;
    localparam int LAT           = 140 + 2 * CORDIC_STAGES;

    localparam logic [16:0] THRESH_RESET = 17'd65503;
    localparam logic [16:0] ONE_Q16      = 17'd65536;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] op;
    } sqrt_t;

    typedef struct packed {
        logic [31:0] p;
        logic [63:0] n;
        logic [31:0] d;
    } div_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            default: r = (i == 5'd31) ? '0 : (34'sd1 <<< (5'd30 - i));
        endcase
        return r;
    endfunction

endpackage

[src/quaternion_slerp_core.sv]
// Quaternion slerp core: fully pipelined chain of sqrt, divide and CORDIC cells.
//
// Input stream s_*: one request carries two quaternions and a blend factor.
// Output stream m_*: one result per request, four Q1.14 components in
// m_tdata and the zero-norm flag in m_tuser. Results keep request order.
// cfg_wr_en/cfg_wr_data load the parallel threshold (Q1.16); write only idle.
// Throughput: one request per cycle while the receiver does not stall.
// The chain holds two 32-cell square roots, two 31-cell dividers and two
// CORDIC rows of CORDIC_STAGES cells in series.
// Reset clears all valid bits and sets the threshold to 65503.
// When the receiver stalls (m_tvalid high, m_tready low) the whole chain
// holds and s_tready drops; bubbles in the chain do not advance meanwhile.
module quaternion_slerp_core
    import qsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, first_z, first_w, second_x, second_y, second_z,
    // second_w, blend, zero padding
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_w
    output logic [63:0]  m_tdata,
    // zero_norm_error
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [16:0]  cfg_wr_data
);

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [16:0]      t;
        logic             zero;
    } sb_a_t;

    typedef struct packed {
        logic [3:0]  sa;
        logic [3:0]  sb;
        logic [16:0] t;
        logic        zero;
    } sb_b_t;

    typedef struct packed {
        logic [3:0][31:0] ua;
        logic [3:0][31:0] ub;
        logic [16:0]      t;
        logic             zero;
        logic             lin;
        logic [30:0]      d;
        logic             slerp;
    } sb_c_t;

    localparam logic signed [35:0] Q30P = 36'sd1073741824;
    localparam logic signed [35:0] Q30N = -36'sd1073741824;

    logic           ce;
    logic [LAT-1:0] vld_reg;
    logic [16:0]    thr_reg;

    assign ce       = ~vld_reg[LAT-1] | m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            thr_reg <= THRESH_RESET;
        end
        else
        begin
            if (ce)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    // input, squares, sums
    sb_a_t       s0_next;
    sb_a_t       s0_reg;
    sb_a_t       s1_reg;
    sb_a_t       s2_reg;
    logic [7:0][30:0] sq_next;
    logic [7:0][30:0] sq_reg;
    logic [32:0] na_reg;
    logic [32:0] nb_reg;
    logic        zero_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s0_next.a[k] = s_tdata[16*k +: 16];
            s0_next.b[k] = s_tdata[64 + 16*k +: 16];
        end
        s0_next.t    = (s_tdata[144:128] > ONE_Q16) ? ONE_Q16 : s_tdata[144:128];
        s0_next.zero = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            sq_next[k]     = 31'($signed(s0_reg.a[k]) * $signed(s0_reg.a[k]));
            sq_next[4 + k] = 31'($signed(s0_reg.b[k]) * $signed(s0_reg.b[k]));
        end
        zero_next = (s0_reg.a == '0) || (s0_reg.b == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s0_reg      <= s0_next;
            sq_reg      <= sq_next;
            s1_reg      <= s0_reg;
            s1_reg.zero <= zero_next;
            na_reg      <= 33'(sq_reg[0]) + 33'(sq_reg[1]) + 33'(sq_reg[2]) + 33'(sq_reg[3]);
            nb_reg      <= 33'(sq_reg[4]) + 33'(sq_reg[5]) + 33'(sq_reg[6]) + 33'(sq_reg[7]);
            s2_reg      <= s1_reg;
        end
    end

    // norm square roots
    sqrt_t sqa_w [SQ_STEPS+1];
    sqrt_t sqb_w [SQ_STEPS+1];
    sb_a_t sba_reg [SQ_STEPS];

    assign sqa_w[0] = '{rem: '0, root: '0, op: {1'b0, na_reg, 30'b0}};
    assign sqb_w[0] = '{rem: '0, root: '0, op: {1'b0, nb_reg, 30'b0}};

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq1
        qsl_sqrt_cell u_sqa (.clk(clk), .ce(ce), .din(sqa_w[k]), .dout(sqa_w[k+1]));
        qsl_sqrt_cell u_sqb (.clk(clk), .ce(ce), .din(sqb_w[k]), .dout(sqb_w[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sba_reg[0] <= s2_reg;
            for (int k = 1; k < SQ_STEPS; k++)
            begin
                sba_reg[k] <= sba_reg[k-1];
            end
        end
    end

    // unit vector division
    div_t        dn_next [8];
    div_t        dn_reg [8];
    sb_b_t       dn_sb_reg;
    logic [15:0] mag;
    logic [63:0] num;
    logic [31:0] nrm;

    always_comb
    begin
        for (int l = 0; l < 8; l++)
        begin
            if (l < 4)
            begin
                mag = sba_reg[SQ_STEPS-1].a[l % 4][15] ? 16'(-sba_reg[SQ_STEPS-1].a[l % 4])
                                                       : sba_reg[SQ_STEPS-1].a[l % 4];
                nrm = sqa_w[SQ_STEPS].root;
            end
            else
            begin
                mag = sba_reg[SQ_STEPS-1].b[l % 4][15] ? 16'(-sba_reg[SQ_STEPS-1].b[l % 4])
                                                       : sba_reg[SQ_STEPS-1].b[l % 4];
                nrm = sqb_w[SQ_STEPS].root;
            end
            num = (64'(mag) << 45) + 64'(nrm[31:1]);
            dn_next[l] = '{p: num[62:31], n: {num[30:0], 33'b0}, d: nrm};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dn_reg <= dn_next;
            for (int k = 0; k < 4; k++)
            begin
                dn_sb_reg.sa[k] <= sba_reg[SQ_STEPS-1].a[k][15];
                dn_sb_reg.sb[k] <= sba_reg[SQ_STEPS-1].b[k][15];
            end
            dn_sb_reg.t    <= sba_reg[SQ_STEPS-1].t;
            dn_sb_reg.zero <= sba_reg[SQ_STEPS-1].zero;
        end
    end

    div_t  dv_w [8][DIV_STEPS+1];
    sb_b_t sbb_reg [DIV_STEPS];

    for (genvar l = 0; l < 8; l++)
    begin : g_dv1
        assign dv_w[l][0] = dn_reg[l];
        for (genvar k = 0; k < DIV_STEPS; k++)
        begin : g_step
            qsl_div_cell u_div (.clk(clk), .ce(ce), .din(dv_w[l][k]), .dout(dv_w[l][k+1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sbb_reg[0] <= dn_sb_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                sbb_reg[k] <= sbb_reg[k-1];
            end
        end
    end

    // unit components, dot product, fold, acos operand
    sb_c_t       u_next;
    sb_c_t       u_reg;
    sb_c_t       p_reg;
    sb_c_t       dr_sb_reg;
    sb_c_t       ab_next;
    sb_c_t       ab_reg;
    sb_c_t       dd_sb_reg;
    logic [30:0] q;
    logic [30:0] qc;
    logic [31:0] uval;
    logic        neg_bit;
    logic signed [63:0] pr_next [4];
    logic signed [63:0] pr_reg [4];
    logic signed [65:0] dsum;
    logic signed [35:0] dr_next;
    logic signed [35:0] dr_reg;
    logic signed [35:0] dc;
    logic [61:0] dd_reg;

    always_comb
    begin
        u_next       = '0;
        u_next.t     = sbb_reg[DIV_STEPS-1].t;
        u_next.zero  = sbb_reg[DIV_STEPS-1].zero;
        for (int l = 0; l < 8; l++)
        begin
            q       = dv_w[l][DIV_STEPS].n[30:0];
            qc      = (q > 31'h40000000) ? 31'h40000000 : q;
            neg_bit = (l < 4) ? sbb_reg[DIV_STEPS-1].sa[l % 4] : sbb_reg[DIV_STEPS-1].sb[l % 4];
            uval    = neg_bit ? 32'(-{1'b0, qc}) : {1'b0, qc};
            if (l < 4)
            begin
                u_next.ua[l % 4] = uval;
            end
            else
            begin
                u_next.ub[l % 4] = uval;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            pr_next[k] = $signed(u_reg.ua[k]) * $signed(u_reg.ub[k]);
        end
        dsum    = 66'(pr_reg[0]) + 66'(pr_reg[1]) + 66'(pr_reg[2]) + 66'(pr_reg[3]);
        dr_next = 36'((dsum + 66'sd536870912) >>> 30);
        if (dr_reg > Q30P)
        begin
            dc = Q30P;
        end
        else if (dr_reg < Q30N)
        begin
            dc = Q30N;
        end
        else
        begin
            dc = dr_reg;
        end
        ab_next = dr_sb_reg;
        if (dc[35])
        begin
            ab_next.d = 31'(-dc);
            for (int k = 0; k < 4; k++)
            begin
                ab_next.ua[k] = 32'(-$signed(dr_sb_reg.ua[k]));
            end
        end
        else
        begin
            ab_next.d = dc[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            u_reg         <= u_next;
            pr_reg        <= pr_next;
            p_reg         <= u_reg;
            dr_reg        <= dr_next;
            dr_sb_reg     <= p_reg;
            ab_reg        <= ab_next;
            dd_reg        <= ab_reg.d * ab_reg.d;
            dd_sb_reg     <= ab_reg;
            dd_sb_reg.lin <= ~(ab_reg.d < {thr_reg, 14'b0});
        end
    end

    // acos: sqrt(1 - d^2), then vectoring CORDIC
    sqrt_t   sqc_w [SQ_STEPS+1];
    sb_c_t   sbc1_reg [SQ_STEPS];
    cordic_t cv_w [CORDIC_STAGES+1];
    sb_c_t   sbc2_reg [CORDIC_STAGES];

    assign sqc_w[0] = '{rem: '0, root: '0, op: (64'd1 << 60) - 64'(dd_reg)};

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq2
        qsl_sqrt_cell u_sqc (.clk(clk), .ce(ce), .din(sqc_w[k]), .dout(sqc_w[k+1]));
    end

    assign cv_w[0] = '{x: 34'(sbc1_reg[SQ_STEPS-1].d),
                       y: 34'(sqc_w[SQ_STEPS].root),
                       z: '0};

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_vec
        qsl_cordic_cell u_vec (.clk(clk), .ce(ce), .stage(5'(k)), .vec(1'b1),
                               .din(cv_w[k]), .dout(cv_w[k+1]));
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sbc1_reg[0] <= dd_sb_reg;
            for (int k = 1; k < SQ_STEPS; k++)
            begin
                sbc1_reg[k] <= sbc1_reg[k-1];
            end
            sbc2_reg[0] <= sbc1_reg[SQ_STEPS-1];
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                sbc2_reg[k] <= sbc2_reg[k-1];
            end
        end
    end

    // partial angles and the three sines
    logic signed [33:0] theta;
    logic [30:0]        tpos;
    logic [16:0]        mt;
    logic [47:0]        pa0;
    logic [47:0]        pa1;
    logic signed [33:0] th_reg [3];
    sb_c_t              th_sb_reg;
    cordic_t            cs_w [3][CORDIC_STAGES+1];
    sb_c_t              sbc3_reg [CORDIC_STAGES];

    always_comb
    begin
        theta = cv_w[CORDIC_STAGES].z;
        tpos  = theta[33] ? '0 : theta[30:0];
        mt    = ONE_Q16 - sbc2_reg[CORDIC_STAGES-1].t;
        pa0   = tpos * mt;
        pa1   = tpos * sbc2_reg[CORDIC_STAGES-1].t;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            th_reg[0] <= theta;
            th_reg[1] <= {2'b00, pa0[47:16]};
            th_reg[2] <= {2'b00, pa1[47:16]};
            th_sb_reg <= sbc2_reg[CORDIC_STAGES-1];
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_sin
        assign cs_w[l][0] = '{x: 34'sd1073741824, y: '0, z: th_reg[l]};
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_step
            qsl_cordic_cell u_rot (.clk(clk), .ce(ce), .stage(5'(k)), .vec(1'b0),
                                   .din(cs_w[l][k]), .dout(cs_w[l][k+1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sbc3_reg[0] <= th_sb_reg;
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                sbc3_reg[k] <= sbc3_reg[k-1];
            end
        end
    end

    // weight ratios
    logic signed [33:0] sth;
    logic signed [33:0] part;
    logic signed [33:0] pc;
    logic               sth_pos;
    logic [63:0]        rnum;
    div_t               rn_next [2];
    div_t               rn_reg [2];
    sb_c_t              rn_sb_next;
    sb_c_t              rn_sb_reg;

    always_comb
    begin
        sth        = cs_w[0][CORDIC_STAGES].y;
        sth_pos    = ~sth[33] && (sth != '0);
        rn_sb_next = sbc3_reg[CORDIC_STAGES-1];
        rn_sb_next.slerp = sth_pos & ~sbc3_reg[CORDIC_STAGES-1].lin;
        for (int l = 0; l < 2; l++)
        begin
            part = cs_w[l+1][CORDIC_STAGES].y;
            if (part[33])
            begin
                pc = '0;
            end
            else if (part > sth)
            begin
                pc = sth;
            end
            else
            begin
                pc = part;
            end
            rnum = (64'(pc[30:0]) << 30) + 64'(sth[31:1]);
            if (sth_pos)
            begin
                rn_next[l] = '{p: rnum[62:31], n: {rnum[30:0], 33'b0}, d: sth[31:0]};
            end
            else
            begin
                rn_next[l] = '{p: '0, n: '0, d: 32'd1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rn_reg    <= rn_next;
            rn_sb_reg <= rn_sb_next;
        end
    end

    div_t  dv2_w [2][DIV_STEPS+1];
    sb_c_t sbc4_reg [DIV_STEPS];

    for (genvar l = 0; l < 2; l++)
    begin : g_dv2
        assign dv2_w[l][0] = rn_reg[l];
        for (genvar k = 0; k < DIV_STEPS; k++)
        begin : g_step
            qsl_div_cell u_div (.clk(clk), .ce(ce), .din(dv2_w[l][k]), .dout(dv2_w[l][k+1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sbc4_reg[0] <= rn_sb_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                sbc4_reg[k] <= sbc4_reg[k-1];
            end
        end
    end

    // weight select, blend, round and clamp
    sb_c_t              wl;
    logic [30:0]        w_next [2];
    logic [30:0]        w_reg [2];
    sb_c_t              w_sb_reg;
    logic signed [63:0] fp_next [4][2];
    logic signed [63:0] fp_reg [4][2];
    logic               fp_zero_reg;
    logic signed [64:0] fs;
    logic signed [18:0] vr;
    logic [63:0]        dat_next;
    logic [63:0]        dat_reg;
    logic               usr_reg;

    always_comb
    begin
        wl = sbc4_reg[DIV_STEPS-1];
        if (wl.slerp)
        begin
            w_next[0] = dv2_w[0][DIV_STEPS].n[30:0];
            w_next[1] = dv2_w[1][DIV_STEPS].n[30:0];
        end
        else
        begin
            w_next[0] = {ONE_Q16 - wl.t, 14'b0};
            w_next[1] = {wl.t, 14'b0};
        end
        for (int k = 0; k < 4; k++)
        begin
            fp_next[k][0] = $signed({1'b0, w_reg[0]}) * $signed(w_sb_reg.ua[k]);
            fp_next[k][1] = $signed({1'b0, w_reg[1]}) * $signed(w_sb_reg.ub[k]);
        end
        for (int k = 0; k < 4; k++)
        begin
            fs = 65'(fp_reg[k][0]) + 65'(fp_reg[k][1]) + 65'sd35184372088832;
            vr = 19'(fs >>> 46);
            if (fp_zero_reg)
            begin
                dat_next[16*k +: 16] = '0;
            end
            else if (vr > 19'sd16384)
            begin
                dat_next[16*k +: 16] = 16'sd16384;
            end
            else if (vr < -19'sd16384)
            begin
                dat_next[16*k +: 16] = -16'sd16384;
            end
            else
            begin
                dat_next[16*k +: 16] = vr[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            w_reg       <= w_next;
            w_sb_reg    <= wl;
            fp_reg      <= fp_next;
            fp_zero_reg <= w_sb_reg.zero;
            dat_reg     <= dat_next;
            usr_reg     <= fp_zero_reg;
        end
    end

    assign m_tdata = dat_reg;
    assign m_tuser = usr_reg;

`include "quaternion_slerp_core_assert.svh"

    `QSL_ASSERT(a_stall_holds_input, (m_tvalid && !m_tready) |-> !s_tready)
    `QSL_ASSERT(a_zero_gives_zeros, (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
    `QSL_ASSERT(a_x_in_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384))
    `QSL_ASSERT_ANY(a_reset_empty, !rst_n |-> !m_tvalid)

endmodule

[src/qsl_sqrt_cell.sv]
// One registered step of the integer square root: one root bit per cell.
module qsl_sqrt_cell
    import qsl_pkg::*;
(
    input  logic  clk,
    input  logic  ce,
    input  sqrt_t din,
    output sqrt_t dout
);

    sqrt_t       data_reg;
    sqrt_t       data_next;
    logic [35:0] cat;
    logic [35:0] trial;
    logic [35:0] diff;

    always_comb
    begin
        cat   = {din.rem, din.op[63:62]};
        trial = {2'b00, din.root, 2'b01};
        diff  = cat - trial;
        data_next.op = {din.op[61:0], 2'b00};
        if (cat >= trial)
        begin
            data_next.rem  = diff[33:0];
            data_next.root = {din.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = cat[33:0];
            data_next.root = {din.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[src/qsl_div_cell.sv]
// One registered step of restoring division: one quotient bit per cell.
module qsl_div_cell
    import qsl_pkg::*;
(
    input  logic clk,
    input  logic ce,
    input  div_t din,
    output div_t dout
);

    div_t        data_reg;
    div_t        data_next;
    logic [32:0] tt;
    logic [32:0] diff;

    always_comb
    begin
        tt   = {din.p, din.n[63]};
        diff = tt - {1'b0, din.d};
        data_next.d = din.d;
        if (tt >= {1'b0, din.d})
        begin
            data_next.p = diff[31:0];
            data_next.n = {din.n[62:0], 1'b1};
        end
        else
        begin
            data_next.p = tt[31:0];
            data_next.n = {din.n[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[src/qsl_cordic_cell.sv]
// One registered CORDIC micro-rotation, vectoring or rotation mode.
module qsl_cordic_cell
    import qsl_pkg::*;
(
    input  logic       clk,
    input  logic       ce,
    input  logic [4:0] stage,
    input  logic       vec,
    input  cordic_t    din,
    output cordic_t    dout
);

    cordic_t            data_reg;
    cordic_t            data_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] ang;
    logic               sel;

    always_comb
    begin
        xs  = din.x >>> stage;
        ys  = din.y >>> stage;
        ang = atan_entry(stage);
        sel = vec ? ~din.y[33] : din.z[33];
        if (sel)
        begin
            data_next.x = din.x + ys;
            data_next.y = din.y - xs;
            data_next.z = din.z + ang;
        end
        else
        begin
            data_next.x = din.x - ys;
            data_next.y = din.y + xs;
            data_next.z = din.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

[tb/quaternion_slerp_core_tb.sv]
// Self-checking testbench for the quaternion slerp core: fixed-point predictor, random streams.
module quaternion_slerp_core_tb;
    import qsl_pkg::*;

    typedef struct packed {
        logic [16:0] blend;
        logic signed [15:0] bw, bz, by, bx;
        logic signed [15:0] aw, az, ay, ax;
    } slerp_req_t;

    typedef struct packed {
        logic zero_norm;
        logic signed [15:0] w, z, y, x;
    } slerp_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en;
    logic [16:0]  cfg_wr_data;

    slerp_req_t pending_reqs[$];
    slerp_res_t expected_results[$];
    logic [16:0] thresh_q16;
    int  failures;
    int  results_seen;
    int  zero_norm_seen;
    int  slerp_path_seen;
    bit  gaps_on;
    int  src_gap;
    int  sink_gap;
    int  hold_cycles;

    quaternion_slerp_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint angle_step(int i);
        longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return tbl[i];
        if (i <= 30)
            return longint'(1) << (30 - i);
        return 0;
    endfunction

    function automatic longint arc_cos(longint d);
        longint x, y, z, nx;
        x = d;
        z = 0;
        y = longint'(int_sqrt((64'd1 << 60) - longint'(d * d)));
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (y >= 0)
            begin
                nx = x + fl_shift(y, i);
                y = y - fl_shift(x, i);
                z += angle_step(i);
            end
            else
            begin
                nx = x - fl_shift(y, i);
                y = y + fl_shift(x, i);
                z -= angle_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint sine_scaled(longint z);
        longint x, y, nx;
        x = longint'(1) << 30;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fl_shift(y, i);
                y = y + fl_shift(x, i);
                z -= angle_step(i);
            end
            else
            begin
                nx = x + fl_shift(y, i);
                y = y - fl_shift(x, i);
                z += angle_step(i);
            end
            x = nx;
        end
        return y;
    endfunction

    function automatic longint sine_ratio(longint part, longint whole);
        longint unsigned p;
        if (part < 0)
            part = 0;
        if (part > whole)
            part = whole;
        p = longint'(part);
        return longint'(((p << 30) + longint'(whole / 2)) / longint'(whole));
    endfunction

    function automatic slerp_res_t predict_slerp(slerp_req_t r);
        slerp_res_t o;
        longint a[4], b[4], ua[4], ub[4];
        longint unsigned na, nb, nra, nrb, mag, t;
        longint dot, w0, w1, v, theta, s_th, th0, th1;
        logic signed [63:0] acc;
        a = '{r.ax, r.ay, r.az, r.aw};
        b = '{r.bx, r.by, r.bz, r.bw};
        na = 0;
        nb = 0;
        o = '0;
        for (int k = 0; k < 4; k++)
        begin
            na += a[k] * a[k];
            nb += b[k] * b[k];
        end
        if (na == 0 || nb == 0)
        begin
            o.zero_norm = 1'b1;
            return o;
        end
        t = (r.blend > ONE_Q16) ? 65536 : r.blend;
        nra = int_sqrt(na << 30);
        nrb = int_sqrt(nb << 30);
        for (int k = 0; k < 4; k++)
        begin
            mag = (a[k] < 0) ? -a[k] : a[k];
            mag = ((mag << 45) + nra / 2) / nra;
            if (mag > (64'd1 << 30))
                mag = 64'd1 << 30;
            ua[k] = (a[k] < 0) ? -longint'(mag) : longint'(mag);
            mag = (b[k] < 0) ? -b[k] : b[k];
            mag = ((mag << 45) + nrb / 2) / nrb;
            if (mag > (64'd1 << 30))
                mag = 64'd1 << 30;
            ub[k] = (b[k] < 0) ? -longint'(mag) : longint'(mag);
        end
        dot = 0;
        for (int k = 0; k < 4; k++)
            dot += ua[k] * ub[k];
        dot = rnd_shift(dot, 30);
        if (dot > (longint'(1) << 30))
            dot = longint'(1) << 30;
        if (dot < -(longint'(1) << 30))
            dot = -(longint'(1) << 30);
        if (dot < 0)
        begin
            for (int k = 0; k < 4; k++)
                ua[k] = -ua[k];
            dot = -dot;
        end
        w0 = longint'(65536 - t) << 14;
        w1 = longint'(t) << 14;
        if (dot < (longint'(thresh_q16) << 14))
        begin
            theta = arc_cos(dot);
            s_th = sine_scaled(theta);
            if (s_th > 0)
            begin
                slerp_path_seen++;
                th0 = longint'((longint'(theta) * (65536 - t)) >> 16);
                th1 = longint'((longint'(theta) * t) >> 16);
                w0 = sine_ratio(sine_scaled(th0), s_th);
                w1 = sine_ratio(sine_scaled(th1), s_th);
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            acc = w0 * ua[k] + w1 * ub[k];
            v = rnd_shift(acc, 46);
            if (v > 16384)
                v = 16384;
            if (v < -16384)
                v = -16384;
            case (k)
                0: o.x = v[15:0];
                1: o.y = v[15:0];
                2: o.z = v[15:0];
                default: o.w = v[15:0];
            endcase
        end
        return o;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                s_tvalid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_tdata  <= 152'(pending_reqs[0]);
                expected_results.push_back(predict_slerp(pending_reqs[0]));
                void'(pending_reqs.pop_front());
                s_tvalid <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0)
                    src_gap <= $urandom_range(1, 11);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (sink_gap > 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            m_tready <= 1'b0;
            sink_gap <= $urandom_range(0, 10);
        end
        else
            m_tready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        slerp_res_t got;
        slerp_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", got);
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.zero_norm)
                    zero_norm_seen++;
                if (got.x !== exp_r.x)
                begin
                    $error("out_x expected %0d actual %0d", exp_r.x, got.x);
                    failures++;
                end
                if (got.y !== exp_r.y)
                begin
                    $error("out_y expected %0d actual %0d", exp_r.y, got.y);
                    failures++;
                end
                if (got.z !== exp_r.z)
                begin
                    $error("out_z expected %0d actual %0d", exp_r.z, got.z);
                    failures++;
                end
                if (got.w !== exp_r.w)
                begin
                    $error("out_w expected %0d actual %0d", exp_r.w, got.w);
                    failures++;
                end
                if (got.zero_norm !== exp_r.zero_norm)
                begin
                    $error("zero_norm_error expected %0d actual %0d",
                        exp_r.zero_norm, got.zero_norm);
                    failures++;
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic slerp_req_t rand_req();
        slerp_req_t r;
        int sel;
        r.ax = rand_comp();
        r.ay = rand_comp();
        r.az = rand_comp();
        r.aw = rand_comp();
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            // near-parallel or anti-parallel second quaternion
            r.bx = r.ax + 16'($urandom_range(0, 6)) - 16'sd3;
            r.by = r.ay + 16'($urandom_range(0, 6)) - 16'sd3;
            r.bz = r.az + 16'($urandom_range(0, 6)) - 16'sd3;
            r.bw = r.aw + 16'($urandom_range(0, 6)) - 16'sd3;
            if (sel == 0)
            begin
                r.bx = -r.bx;
                r.by = -r.by;
                r.bz = -r.bz;
                r.bw = -r.bw;
            end
        end
        else
        begin
            r.bx = rand_comp();
            r.by = rand_comp();
            r.bz = rand_comp();
            r.bw = rand_comp();
        end
        if ($urandom_range(0, 49) == 0)
            {r.ax, r.ay, r.az, r.aw} = '0;
        if ($urandom_range(0, 49) == 0)
            {r.bx, r.by, r.bz, r.bw} = '0;
        case ($urandom_range(0, 7))
            0: r.blend = 17'd0;
            1: r.blend = ONE_Q16;
            2: r.blend = 17'($urandom_range(65537, 131071));
            default: r.blend = 17'($urandom_range(0, 65536));
        endcase
        return r;
    endfunction

    function automatic slerp_req_t make_req(int ax, int ay, int az, int aw,
                                             int bx, int by, int bz, int bw, int t);
        slerp_req_t r;
        r.ax = ax; r.ay = ay; r.az = az; r.aw = aw;
        r.bx = bx; r.by = by; r.bz = bz; r.bw = bw;
        r.blend = t;
        return r;
    endfunction

    task automatic drain_and_config(input logic [16:0] v);
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        thresh_q16  = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [16:0] thresholds[5];
        failures = 0;
        results_seen = 0;
        zero_norm_seen = 0;
        slerp_path_seen = 0;
        gaps_on = 1'b1;
        hold_cycles = 0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        thresh_q16 = THRESH_RESET;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_reqs.push_back(make_req(0, 0, 0, 0, 1, 2, 3, 4, 100));
        pending_reqs.push_back(make_req(1, 2, 3, 4, 0, 0, 0, 0, 100));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(32767, 32767, 32767, 32767,
                                        -32768, -32768, -32768, -32768, 32768));
        pending_reqs.push_back(make_req(-32768, 0, 0, 0, 0, 0, 0, 32767, 65536));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 1, 0, 0, 65536));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 1, 0, 0, 131071));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 1, 0, 0, 65537));
        pending_reqs.push_back(make_req(5, 5, 5, 5, 5, 5, 5, 5, 20000));
        pending_reqs.push_back(make_req(5, 5, 5, 5, -5, -5, -5, -5, 20000));
        pending_reqs.push_back(make_req(1000, 0, 0, 0, 1000, 1, 0, 0, 30000));
        pending_reqs.push_back(make_req(1000, 0, 0, 0, -1000, 30, 0, 0, 30000));
        pending_reqs.push_back(make_req(1, 0, 0, 0, -1, 0, 0, 0, 40000));
        pending_reqs.push_back(make_req(3, -4, 7, -1, 9, 2, -6, 8, 50000));
        pending_reqs.push_back(make_req(-1, -1, -1, -1, 1, 1, 1, 1, 1));

        thresholds = '{17'd65536, 17'd0, 17'd60000, 17'd65535, THRESH_RESET};
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_config(thresholds[ph]);
            if (ph == 0)
            begin
                // long receiver stall while the sender keeps offering
                hold_cycles = 400;
                for (int i = 0; i < 400; i++)
                    pending_reqs.push_back(rand_req());
            end
            if (ph == 4)
                gaps_on = 1'b0;
            for (int i = 0; i < 320; i++)
                pending_reqs.push_back(rand_req());
        end

        while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        $display("Covered %0d results, %0d zero-norm, %0d via the trig path,",
            results_seen, zero_norm_seen, slerp_path_seen);
        $display("five threshold settings including 0, 65535, 65536 and reset.");
        if (failures == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
